// ===== rtl/core/ray_triangle_closest_hit_macros.svh =====
// Assertion macros shared by the ray/triangle block
`ifndef RAY_TRIANGLE_CLOSEST_HIT_MACROS_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_MACROS_SVH

// same-cycle implication, held off during reset
`define RTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtc check failed");

// next-cycle implication, held off during reset
`define RTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtc check failed");

`endif

// ===== rtl/core/rtc_pkg.sv =====
package rtc_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIVLD,
        S_DIV,
        S_CHECK,
        S_COMMIT,
        S_DONE
    } t_state;

    // multiply steps, in issue order
    typedef enum logic [4:0] {
        OP_PV0A, OP_PV0B, OP_PV1A, OP_PV1B, OP_PV2A, OP_PV2B,
        OP_DETA, OP_DETB, OP_DETC,
        OP_UA, OP_UB, OP_UC,
        OP_QV0A, OP_QV0B, OP_QV1A, OP_QV1B, OP_QV2A, OP_QV2B,
        OP_VA, OP_VB, OP_VC,
        OP_TA, OP_TB, OP_TC,
        OP_PX, OP_PY, OP_PZ
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ORG_X,
        CFG_ORG_Y,
        CFG_ORG_Z,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_DIR_Z,
        CFG_MAX_DIST,
        CFG_DET_EPS
    } t_cfg_idx;

    localparam int CFG_DATA_W = 32;

    // control for one multiply step
    typedef struct packed {
        logic first;
        logic last;
        logic neg;
        logic base_org;
    } t_op_ctl;

endpackage

// ===== rtl/core/rtc_if.sv =====
interface rtc_tri_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
    logic [15:0]        triangle_index;
    logic               last_triangle;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, triangle_index,
               last_triangle,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
               vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, triangle_index,
               last_triangle,
        output ready
    );
endinterface

interface rtc_hit_if;
    logic               valid;
    logic               ready;
    logic               hit_flag;
    logic [30:0]        hit_distance;
    logic signed [31:0] hit_point_x;
    logic signed [31:0] hit_point_y;
    logic signed [31:0] hit_point_z;
    logic [15:0]        hit_triangle;

    modport source (
        output valid, hit_flag, hit_distance, hit_point_x, hit_point_y, hit_point_z,
               hit_triangle,
        input  ready
    );
    modport sink (
        input  valid, hit_flag, hit_distance, hit_point_x, hit_point_y, hit_point_z,
               hit_triangle,
        output ready
    );
endinterface

// ===== rtl/core/ray_triangle_closest_hit.sv =====
// channel   | dir | handshake           | item
// i_tri     | in  | valid/ready         | three vertices, index, last mark
// o_hit     | out | valid/ready         | hit flag, distance, point, index
// i_cfg_*   | in  | write enable only   | ray registers, index i_cfg_idx
//
// Each triangle runs its multiply/accumulate steps on one shared 32x32
// multiplier plus up to three divides on a one-bit-per-cycle divider,
// and ends early when a test rejects it. Reset is synchronous, active
// low; it loads the register defaults and clears the pass. A last item
// waits while the previous result is still held on o_hit.
`include "ray_triangle_closest_hit_macros.svh"

module ray_triangle_closest_hit
    import rtc_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rtc_tri_if.sink               i_tri,
    rtc_hit_if.source             o_hit,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int ACC_W = 66;
    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

    // configuration
    logic signed [31:0] r_org [3];
    logic signed [17:0] r_dir [3];
    logic [30:0]        r_max;
    logic [15:0]        r_eps;

    // pass state
    logic [30:0]           r_closest;
    logic                  r_any;
    logic signed [31:0]    r_best [3];
    logic [INDEX_BITS-1:0] r_best_idx;

    // item working set
    t_state                r_state, n_state;
    t_op                   r_op;
    logic signed [31:0]    r_e1 [3];
    logic signed [31:0]    r_e2 [3];
    logic signed [31:0]    r_tv [3];
    logic signed [31:0]    r_pv [3];
    logic signed [31:0]    r_qv [3];
    logic signed [31:0]    r_pt [3];
    logic signed [31:0]    r_det, r_num, r_u, r_t;
    logic [INDEX_BITS-1:0] r_idx;
    logic                  r_last;
    logic signed [63:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;

    // divider
    logic [31:0]      r_rem, r_dsr;
    logic [DVD_W-1:0] r_dvd, r_quo;
    logic             r_qneg;
    logic [CNT_W-1:0] r_cnt;

    // output register
    logic               r_out_valid;
    logic               r_out_flag;
    logic [30:0]        r_out_dist;
    logic signed [31:0] r_out_pt [3];
    logic [15:0]        r_out_tri;

    logic               tri_ready;
    logic               out_free;
    logic signed [31:0] opa, opb;
    t_op_ctl            ctl;
    logic signed [ACC_W-1:0] acc_base, acc_term, acc_next;
    logic signed [31:0] acc_sat;
    logic [32:0]        trial;
    logic signed [31:0] quo_sat;
    logic [31:0]        det_abs, num_abs;
    logic               chk_ok;
    logic [INDEX_BITS+15:0] idx_in_ext, idx_out_ext;

    // saturating edge subtract
    function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d[32] != d[31]) return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return d[31:0];
    endfunction

    assign idx_in_ext  = (INDEX_BITS+16)'(i_tri.triangle_index);
    assign idx_out_ext = {16'b0, r_best_idx};

    // operand select per multiply step
    always_comb begin
        opa = '0;
        opb = '0;
        ctl = '0;
        unique case (r_op)
            OP_PV0A: begin opa = 32'(r_dir[1]); opb = r_e2[2]; ctl = 4'b1000; end
            OP_PV0B: begin opa = 32'(r_dir[2]); opb = r_e2[1]; ctl = 4'b0110; end
            OP_PV1A: begin opa = 32'(r_dir[2]); opb = r_e2[0]; ctl = 4'b1000; end
            OP_PV1B: begin opa = 32'(r_dir[0]); opb = r_e2[2]; ctl = 4'b0110; end
            OP_PV2A: begin opa = 32'(r_dir[0]); opb = r_e2[1]; ctl = 4'b1000; end
            OP_PV2B: begin opa = 32'(r_dir[1]); opb = r_e2[0]; ctl = 4'b0110; end
            OP_DETA: begin opa = r_e1[0]; opb = r_pv[0]; ctl = 4'b1000; end
            OP_DETB: begin opa = r_e1[1]; opb = r_pv[1]; ctl = 4'b0000; end
            OP_DETC: begin opa = r_e1[2]; opb = r_pv[2]; ctl = 4'b0100; end
            OP_UA:   begin opa = r_tv[0]; opb = r_pv[0]; ctl = 4'b1000; end
            OP_UB:   begin opa = r_tv[1]; opb = r_pv[1]; ctl = 4'b0000; end
            OP_UC:   begin opa = r_tv[2]; opb = r_pv[2]; ctl = 4'b0100; end
            OP_QV0A: begin opa = r_tv[1]; opb = r_e1[2]; ctl = 4'b1000; end
            OP_QV0B: begin opa = r_tv[2]; opb = r_e1[1]; ctl = 4'b0110; end
            OP_QV1A: begin opa = r_tv[2]; opb = r_e1[0]; ctl = 4'b1000; end
            OP_QV1B: begin opa = r_tv[0]; opb = r_e1[2]; ctl = 4'b0110; end
            OP_QV2A: begin opa = r_tv[0]; opb = r_e1[1]; ctl = 4'b1000; end
            OP_QV2B: begin opa = r_tv[1]; opb = r_e1[0]; ctl = 4'b0110; end
            OP_VA:   begin opa = 32'(r_dir[0]); opb = r_qv[0]; ctl = 4'b1000; end
            OP_VB:   begin opa = 32'(r_dir[1]); opb = r_qv[1]; ctl = 4'b0000; end
            OP_VC:   begin opa = 32'(r_dir[2]); opb = r_qv[2]; ctl = 4'b0100; end
            OP_TA:   begin opa = r_e2[0]; opb = r_qv[0]; ctl = 4'b1000; end
            OP_TB:   begin opa = r_e2[1]; opb = r_qv[1]; ctl = 4'b0000; end
            OP_TC:   begin opa = r_e2[2]; opb = r_qv[2]; ctl = 4'b0100; end
            OP_PX:   begin opa = 32'(r_dir[0]); opb = r_t; ctl = 4'b1101; end
            OP_PY:   begin opa = 32'(r_dir[1]); opb = r_t; ctl = 4'b1101; end
            OP_PZ:   begin opa = 32'(r_dir[2]); opb = r_t; ctl = 4'b1101; end
            default: begin opa = '0; opb = '0; ctl = '0; end
        endcase
    end

    // accumulate: floor-shifted product onto running sum (or origin), then saturate
    always_comb begin
        if (!ctl.first) acc_base = r_acc;
        else if (ctl.base_org) begin
            unique case (r_op)
                OP_PX:   acc_base = ACC_W'(r_org[0]);
                OP_PY:   acc_base = ACC_W'(r_org[1]);
                default: acc_base = ACC_W'(r_org[2]);
            endcase
        end else acc_base = '0;
        acc_term = ACC_W'(r_prod) >>> FRAC_BITS;
        acc_next = ctl.neg ? acc_base - acc_term : acc_base + acc_term;
        if (acc_next[ACC_W-1:31] == '0 || acc_next[ACC_W-1:31] == '1)
            acc_sat = acc_next[31:0];
        else
            acc_sat = acc_next[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    // divider step and quotient saturation
    assign trial   = {r_rem, r_dvd[DVD_W-1]};
    assign det_abs = r_det[31] ? 32'(-33'(r_det)) : 32'(r_det);
    assign num_abs = r_num[31] ? 32'(-33'(r_num)) : 32'(r_num);
    always_comb begin
        if (!r_qneg)
            quo_sat = (|r_quo[DVD_W-1:31]) ? 32'sh7FFF_FFFF : r_quo[31:0];
        else if ((|r_quo[DVD_W-1:32]) || (r_quo[31] && (|r_quo[30:0])))
            quo_sat = 32'sh8000_0000;
        else
            quo_sat = 32'(-r_quo[31:0]);
    end

    // acceptance tests on the determinant and after each divide
    always_comb begin
        unique case (r_op)
            OP_DETC: chk_ok = (r_det != '0) && (det_abs >= 32'(r_eps));
            OP_UC:   chk_ok = !quo_sat[31] && (34'(quo_sat) <= ONE);
            OP_VC:   chk_ok = !quo_sat[31] && (34'(r_u) + 34'(quo_sat) <= ONE);
            OP_TC:   chk_ok = !quo_sat[31] && (quo_sat[30:0] <= r_closest);
            default: chk_ok = 1'b0;
        endcase
    end

    assign out_free = !r_out_valid || o_hit.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_tri.valid) n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC: begin
                if (!ctl.last || r_op == OP_PX || r_op == OP_PY) n_state = S_MUL;
                else if (r_op == OP_PZ) n_state = S_COMMIT;
                else if (r_op == OP_DETC) n_state = S_CHECK;
                else if (r_op == OP_UC || r_op == OP_VC || r_op == OP_TC)
                    n_state = S_DIVLD;
                else n_state = S_MUL;
            end
            S_DIVLD:  n_state = S_DIV;
            S_DIV:    if (r_cnt == CNT_W'(1)) n_state = S_CHECK;
            S_CHECK:  n_state = chk_ok ? S_MUL : S_DONE;
            S_COMMIT: n_state = S_DONE;
            S_DONE:   if (!r_last || out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        tri_ready = (r_state == S_IDLE);
    end

    assign i_tri.ready        = tri_ready;
    assign o_hit.valid        = r_out_valid;
    assign o_hit.hit_flag     = r_out_flag;
    assign o_hit.hit_distance = r_out_dist;
    assign o_hit.hit_point_x  = r_out_pt[0];
    assign o_hit.hit_point_y  = r_out_pt[1];
    assign o_hit.hit_point_z  = r_out_pt[2];
    assign o_hit.hit_triangle = r_out_tri;

    // control, configuration and pass state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_PV0A;
            r_out_valid <= 1'b0;
            r_org[0]   <= '0;
            r_org[1]   <= '0;
            r_org[2]   <= '0;
            r_dir[0]   <= 18'sd65536;
            r_dir[1]   <= '0;
            r_dir[2]   <= '0;
            r_max      <= 31'd6553600;
            r_eps      <= 16'd66;
            r_closest  <= 31'd6553600;
            r_any      <= 1'b0;
            r_best[0]  <= '0;
            r_best[1]  <= '0;
            r_best[2]  <= '0;
            r_best_idx <= '0;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;

            // result valid: set when a pass ends, cleared once taken
            if (r_state == S_DONE && r_last && out_free) r_out_valid <= 1'b1;
            else if (o_hit.ready) r_out_valid <= 1'b0;

            // register writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ORG_X:    r_org[0] <= i_cfg_data;
                    CFG_ORG_Y:    r_org[1] <= i_cfg_data;
                    CFG_ORG_Z:    r_org[2] <= i_cfg_data;
                    CFG_DIR_X:    r_dir[0] <= i_cfg_data[17:0];
                    CFG_DIR_Y:    r_dir[1] <= i_cfg_data[17:0];
                    CFG_DIR_Z:    r_dir[2] <= i_cfg_data[17:0];
                    CFG_MAX_DIST: begin
                        r_max     <= i_cfg_data[30:0];
                        r_closest <= i_cfg_data[30:0];
                    end
                    CFG_DET_EPS:  r_eps <= i_cfg_data[15:0];
                    default:      r_eps <= r_eps;
                endcase
            end

            unique case (r_state)
                S_IDLE:   r_op <= OP_PV0A;
                S_ACC:    if (n_state == S_MUL) r_op <= t_op'(r_op + 5'd1);
                S_DIVLD:  r_cnt <= CNT_W'(DVD_W);
                S_DIV:    r_cnt <= r_cnt - CNT_W'(1);
                S_CHECK:  if (chk_ok) r_op <= t_op'(r_op + 5'd1);
                S_COMMIT: begin
                    r_closest  <= r_t[30:0];
                    r_any      <= 1'b1;
                    r_best[0]  <= r_pt[0];
                    r_best[1]  <= r_pt[1];
                    r_best[2]  <= r_pt[2];
                    r_best_idx <= r_idx;
                end
                S_DONE: begin
                    // result out, then start a fresh pass
                    if (r_last && out_free) begin
                        r_closest   <= r_max;
                        r_any       <= 1'b0;
                        r_best[0]   <= '0;
                        r_best[1]   <= '0;
                        r_best[2]   <= '0;
                        r_best_idx  <= '0;
                    end
                end
                default: r_op <= r_op;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_e1[0] <= sat_sub(i_tri.vertex_b_x, i_tri.vertex_a_x);
                r_e1[1] <= sat_sub(i_tri.vertex_b_y, i_tri.vertex_a_y);
                r_e1[2] <= sat_sub(i_tri.vertex_b_z, i_tri.vertex_a_z);
                r_e2[0] <= sat_sub(i_tri.vertex_c_x, i_tri.vertex_a_x);
                r_e2[1] <= sat_sub(i_tri.vertex_c_y, i_tri.vertex_a_y);
                r_e2[2] <= sat_sub(i_tri.vertex_c_z, i_tri.vertex_a_z);
                r_tv[0] <= sat_sub(r_org[0], i_tri.vertex_a_x);
                r_tv[1] <= sat_sub(r_org[1], i_tri.vertex_a_y);
                r_tv[2] <= sat_sub(r_org[2], i_tri.vertex_a_z);
                r_idx   <= idx_in_ext[INDEX_BITS-1:0];
                r_last  <= i_tri.last_triangle;
            end
            S_MUL: r_prod <= 64'(opa) * 64'(opb);
            S_ACC: begin
                r_acc <= acc_next;
                if (ctl.last) begin
                    unique case (r_op)
                        OP_PV0B: r_pv[0] <= acc_sat;
                        OP_PV1B: r_pv[1] <= acc_sat;
                        OP_PV2B: r_pv[2] <= acc_sat;
                        OP_QV0B: r_qv[0] <= acc_sat;
                        OP_QV1B: r_qv[1] <= acc_sat;
                        OP_QV2B: r_qv[2] <= acc_sat;
                        OP_DETC: r_det   <= acc_sat;
                        OP_PX:   r_pt[0] <= acc_sat;
                        OP_PY:   r_pt[1] <= acc_sat;
                        OP_PZ:   r_pt[2] <= acc_sat;
                        default: r_num   <= acc_sat;
                    endcase
                end
            end
            S_DIVLD: begin
                r_rem  <= '0;
                r_dvd  <= {num_abs, {FRAC_BITS{1'b0}}};
                r_dsr  <= det_abs;
                r_quo  <= '0;
                r_qneg <= r_num[31] ^ r_det[31];
            end
            S_DIV: begin
                // one quotient bit per cycle
                r_dvd <= r_dvd << 1;
                if (trial >= {1'b0, r_dsr}) begin
                    r_rem <= 32'(trial - {1'b0, r_dsr});
                    r_quo <= {r_quo[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[31:0];
                    r_quo <= {r_quo[DVD_W-2:0], 1'b0};
                end
            end
            S_CHECK: begin
                if (r_op == OP_UC) r_u <= quo_sat;
                if (r_op == OP_TC) r_t <= quo_sat;
            end
            S_DONE: begin
                if (r_last && out_free) begin
                    r_out_flag  <= r_any;
                    r_out_dist  <= r_any ? r_closest : '0;
                    r_out_pt[0] <= r_best[0];
                    r_out_pt[1] <= r_best[1];
                    r_out_pt[2] <= r_best[2];
                    r_out_tri   <= idx_out_ext[15:0];
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    // checks
    `RTC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_tri.valid && i_tri.ready, !i_tri.ready)
    `RTC_ASSERT_NOW(a_no_hit_zero_dist, i_clk, i_rst_n,
        o_hit.valid && !o_hit.hit_flag, o_hit.hit_distance == '0)
    `RTC_ASSERT_NOW(a_div_count_range, i_clk, i_rst_n,
        r_state == S_DIV, r_cnt != '0 && r_cnt <= CNT_W'(DVD_W))

endmodule
